>>> hdl/power_debounced_alarm_arming_fsm_top_defines.svh
// Assertion macros shared by the power alarm arming checker
`ifndef POWER_DEBOUNCED_ALARM_ARMING_FSM_TOP_DEFINES_SVH
`define POWER_DEBOUNCED_ALARM_ARMING_FSM_TOP_DEFINES_SVH

// check a property outside reset
`define PDAA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check a property at every edge, reset included
`define PDAA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/pdaa_pkg.sv
// Types and codes for the power debounced alarm arming block
`timescale 1ns / 1ps

package pdaa_pkg;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_UPDATE  = 2'd1,
    CMD_SILENCE = 2'd2,
    CMD_REARM   = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    ST_RIDING    = 5'b00001,
    ST_COOLDOWN  = 5'b00010,
    ST_IDLE      = 5'b00100,
    ST_ARMED     = 5'b01000,
    ST_TRIGGERED = 5'b10000
  } state_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_RIDE      = 3'd1,
    EV_LOST      = 3'd2,
    EV_SCREENOFF = 3'd3,
    EV_MOTION    = 3'd4,
    EV_CLEARED   = 3'd5
  } event_e;

  typedef logic [2:0] mode_t;

  localparam mode_t MODE_RIDING    = 3'd0;
  localparam mode_t MODE_COOLDOWN  = 3'd1;
  localparam mode_t MODE_IDLE      = 3'd2;
  localparam mode_t MODE_ARMED     = 3'd3;
  localparam mode_t MODE_TRIGGERED = 3'd4;

  localparam logic [1:0] CFG_RETURN_CONFIRM = 2'd0;
  localparam logic [1:0] CFG_LOSS_CONFIRM   = 2'd1;
  localparam logic [1:0] CFG_ARMING_DELAY   = 2'd2;

  localparam logic [31:0] RETURN_CONFIRM_RST = 32'd200;
  localparam logic [31:0] LOSS_CONFIRM_RST   = 32'd2000;
  localparam logic [31:0] ARMING_DELAY_RST   = 32'd30000;

  function automatic mode_t state_to_mode(state_e st);
    mode_t m;
    unique case (st)
      ST_RIDING:    m = MODE_RIDING;
      ST_COOLDOWN:  m = MODE_COOLDOWN;
      ST_IDLE:      m = MODE_IDLE;
      ST_ARMED:     m = MODE_ARMED;
      ST_TRIGGERED: m = MODE_TRIGGERED;
      default:      m = MODE_COOLDOWN;
    endcase
    return m;
  endfunction

endpackage

>>> hdl/power_debounced_alarm_arming_fsm_top.sv
// Power debounced alarm arming state machine, top level
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------------
//   in       | in_valid_i / in_stall_o    | cmd, ext_power, alarm_on, motion, now_ms
//   out      | out_valid_o / out_stall_i  | event_res, mode, power_ok, ms_to_screen_off
//   cfg      | cfg_valid_i / cfg_ready_o  | cfg_index, cfg_data
//
// One request per cycle unless the result stalls; a request passes the input register, then the result register.
// The debounce compare, the cooldown compare and the time-left subtract sit in one
// stage between the two registers, and the state updates as the result is captured.
// A stalled result holds while one more request waits in the input register.
// Reset loads the default confirm and delay times and the cooldown state.
`timescale 1ns / 1ps

module power_debounced_alarm_arming_fsm_top
  import pdaa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic        ext_power_i,
  input  logic        alarm_on_i,
  input  logic        motion_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [2:0]  mode_o,
  output logic        power_ok_o,
  output logic [31:0] ms_to_screen_off_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] return_confirm_q, loss_confirm_q, arming_delay_q;

  logic        item_valid_q;
  cmd_e        cmd_q;
  logic        raw_q, alarm_q, mov_q;
  logic [31:0] now_q;

  logic        conf_q, conf_d;
  logic        pend_q, pend_d;
  logic [31:0] since_q, since_d;
  logic [31:0] loss_q, loss_d;
  state_e      st_q, st_d;

  logic        out_valid_q;
  event_e      ev_q, ev_d;
  mode_t       mode_q;
  logic        pwr_q;
  logic [31:0] left_q, left_d;

  logic        out_free, fire, in_take;
  logic [31:0] need, held, cool_gone, gone;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      return_confirm_q <= RETURN_CONFIRM_RST;
      loss_confirm_q   <= LOSS_CONFIRM_RST;
      arming_delay_q   <= ARMING_DELAY_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RETURN_CONFIRM: return_confirm_q <= cfg_data_i;
        CFG_LOSS_CONFIRM:   loss_confirm_q   <= cfg_data_i;
        CFG_ARMING_DELAY:   arming_delay_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_take) begin
      item_valid_q <= 1'b1;
    end else if (fire) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= cmd_e'(cmd_i);
      raw_q   <= ext_power_i;
      alarm_q <= alarm_on_i;
      mov_q   <= motion_i;
      now_q   <= now_ms_i;
    end
  end

  assign need      = pend_q ? return_confirm_q : loss_confirm_q;
  assign held      = now_q - since_q;
  assign cool_gone = now_q - loss_q;

  always_comb begin
    conf_d = conf_q;
    pend_d = pend_q;
    since_d = since_q;
    loss_d = loss_q;
    st_d = st_q;
    ev_d = EV_NONE;
    unique case (cmd_q)
      CMD_START: begin
        conf_d  = raw_q;
        pend_d  = raw_q;
        since_d = now_q;
        loss_d  = now_q;
        st_d    = raw_q ? ST_RIDING : ST_COOLDOWN;
      end
      CMD_UPDATE: begin
        if (raw_q != pend_q) begin
          pend_d  = raw_q;
          since_d = now_q;
        end else if (pend_q != conf_q && held >= need) begin
          conf_d = pend_q;
        end
        if (conf_d && !conf_q) begin
          st_d = ST_RIDING;
          ev_d = EV_RIDE;
        end else if (!conf_d && conf_q) begin
          st_d   = ST_COOLDOWN;
          loss_d = now_q;
          ev_d   = EV_LOST;
        end else begin
          unique case (st_q)
            ST_COOLDOWN: begin
              if (cool_gone >= arming_delay_q) begin
                st_d = alarm_q ? ST_ARMED : ST_IDLE;
                ev_d = EV_SCREENOFF;
              end
            end
            ST_IDLE: begin
              if (alarm_q) st_d = ST_ARMED;
            end
            ST_ARMED: begin
              if (!alarm_q) begin
                st_d = ST_IDLE;
              end else if (mov_q) begin
                st_d = ST_TRIGGERED;
                ev_d = EV_MOTION;
              end
            end
            ST_TRIGGERED: begin
              if (!alarm_q) begin
                st_d = ST_IDLE;
                ev_d = EV_CLEARED;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_SILENCE: begin
        if (st_q == ST_TRIGGERED) begin
          st_d   = ST_IDLE;
          loss_d = now_q;
        end
      end
      CMD_REARM: begin
        if (st_q == ST_TRIGGERED) st_d = ST_ARMED;
      end
      default: ;
    endcase
  end

  assign gone = now_q - loss_d;

  always_comb begin
    if (st_d != ST_COOLDOWN || gone >= arming_delay_q) begin
      left_d = '0;
    end else begin
      left_d = arming_delay_q - gone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q  <= 1'b0;
      pend_q  <= 1'b0;
      since_q <= '0;
      loss_q  <= '0;
      st_q    <= ST_COOLDOWN;
    end else if (fire) begin
      conf_q  <= conf_d;
      pend_q  <= pend_d;
      since_q <= since_d;
      loss_q  <= loss_d;
      st_q    <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ev_q   <= ev_d;
      mode_q <= state_to_mode(st_d);
      pwr_q  <= conf_d;
      left_q <= left_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign event_res_o        = ev_q;
  assign mode_o             = mode_q;
  assign power_ok_o         = pwr_q;
  assign ms_to_screen_off_o = left_q;

endmodule

>>> hdl/pdaa_checker.sv
// Port-level checks for the power alarm arming block, with its bind
`timescale 1ns / 1ps

`include "power_debounced_alarm_arming_fsm_top_defines.svh"

module pdaa_checker
  import pdaa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  event_res_o,
  input logic [2:0]  mode_o,
  input logic        power_ok_o,
  input logic [31:0] ms_to_screen_off_o
);

  property p_stall_holds;
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) && $stable(mode_o)
      && $stable(power_ok_o) && $stable(ms_to_screen_off_o);
  endproperty

  property p_left_only_cooldown;
    out_valid_o && mode_o != MODE_COOLDOWN |-> ms_to_screen_off_o == 32'd0;
  endproperty

  property p_power_events;
    out_valid_o && (event_res_o == EV_RIDE || event_res_o == EV_LOST) |->
      (event_res_o == EV_RIDE) == power_ok_o
      && ((event_res_o == EV_RIDE && mode_o == MODE_RIDING)
          || (event_res_o == EV_LOST && mode_o == MODE_COOLDOWN));
  endproperty

  property p_alarm_events;
    out_valid_o && (event_res_o == EV_MOTION || event_res_o == EV_CLEARED) |->
      !power_ok_o
      && ((event_res_o == EV_MOTION && mode_o == MODE_TRIGGERED)
          || (event_res_o == EV_CLEARED && mode_o == MODE_IDLE));
  endproperty

  `PDAA_ASSERT_ALWAYS(a_reset_no_result, (!rst_ni |-> !out_valid_o), "result valid in reset")

  `PDAA_ASSERT(a_stall_holds, p_stall_holds, "stalled result changed")

  `PDAA_ASSERT(a_left_only_cooldown, p_left_only_cooldown, "time left outside cooldown")

  `PDAA_ASSERT(a_power_events, p_power_events, "power event state mismatch")

  `PDAA_ASSERT(a_alarm_events, p_alarm_events, "alarm event state mismatch")

endmodule

bind power_debounced_alarm_arming_fsm_top pdaa_checker u_pdaa_checker (.*);
